### sv/kwspc_pkg.sv
// ----------------------------------------------------------------------------
// kwspc_pkg
// Shared types, constants and helpers of the keyword posterior confidence core.
// ----------------------------------------------------------------------------
package kwspc_pkg;

  // Sizes
  localparam int MAX_KW       = 4;
  localparam int SMOOTH_DEPTH = 16;
  localparam int WINDOW_DEPTH = 64;
  localparam int POST_W       = 17;
  localparam int ROW_W        = 7;
  localparam int FRAME_W      = 16;
  localparam int TIME_W       = 18;
  localparam int ACC_W        = POST_W + $clog2(SMOOTH_DEPTH);
  localparam int RAW_AW       = $clog2(SMOOTH_DEPTH);
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int DP_DEPTH     = WINDOW_DEPTH + 1;
  localparam int DP_AW        = $clog2(DP_DEPTH);
  localparam int DIV_NW       = 33;
  localparam int DIV_DW       = 17;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 17;

  localparam logic [POST_W-1:0] Q_ONE = 17'h10000;

  typedef logic [POST_W-1:0] post_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef post_t [MAX_KW-1:0] kw_vec_t;
  typedef row_t  [MAX_KW-1:0] row_vec_t;

  typedef struct packed {
    row_vec_t row;
    kw_vec_t  score;
  } dp_word_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_KW    = 3'd0,
    CFG_SMOOTH    = 3'd1,
    CFG_MAX_WIN   = 3'd2,
    CFG_GAP_LIMIT = 3'd3,
    CFG_THRESHOLD = 3'd4
  } cfg_idx_t;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_ZERO, OP_SRD, OP_SACC, OP_SDGO, OP_SDWT, OP_SWR,
    OP_DRD, OP_DMUL, OP_DUPD, OP_BRD0, OP_BLAT0, OP_BRD, OP_BLAT, OP_BDGO,
    OP_BDWT, OP_RINIT, OP_RMID, OP_RPOW, OP_RCMP, OP_FIN
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic sm_last;
    logic lane_last;
    logic div_done;
    logic dp_last;
    logic nk_one;
    logic bt_last;
    logic root_open;
    logic pow_done;
    logic out_free;
  } stat_t;

  // Truncating Q1.16 product
  function automatic post_t qmul(post_t a, post_t b);
    logic [2*POST_W-1:0] pr;
    pr = (2*POST_W)'(a) * (2*POST_W)'(b);
    return pr[POST_W+15:16];
  endfunction

  // Clip a posterior to one
  function automatic post_t qsat(post_t v);
    return (v > Q_ONE) ? Q_ONE : v;
  endfunction

endpackage

### sv/kwspc_if.sv
// ----------------------------------------------------------------------------
// kwspc_if
// Frame and result channels of the keyword posterior confidence core.
// ----------------------------------------------------------------------------
interface kwspc_frame_if;
  logic                  valid;
  logic                  ready;
  logic                  first_frame;
  kwspc_pkg::post_t      post_kw1;
  kwspc_pkg::post_t      post_kw2;
  kwspc_pkg::post_t      post_kw3;
  kwspc_pkg::post_t      post_kw4;

  modport source(output valid, first_frame, post_kw1, post_kw2, post_kw3, post_kw4,
                 input ready);
  modport sink(input valid, first_frame, post_kw1, post_kw2, post_kw3, post_kw4,
               output ready);
endinterface

interface kwspc_result_if;
  logic                  valid;
  logic                  ready;
  logic [15:0]           frame_index;
  kwspc_pkg::post_t      overall_score;
  kwspc_pkg::post_t      score_kw1;
  kwspc_pkg::post_t      score_kw2;
  kwspc_pkg::post_t      score_kw3;
  kwspc_pkg::post_t      score_kw4;
  logic [15:0]           time_kw1;
  logic [15:0]           time_kw2;
  logic [15:0]           time_kw3;
  logic [15:0]           time_kw4;
  logic                  wake_hit;
  logic                  wake_latched;

  modport source(output valid, frame_index, overall_score, score_kw1, score_kw2,
                 score_kw3, score_kw4, time_kw1, time_kw2, time_kw3, time_kw4,
                 wake_hit, wake_latched, input ready);
  modport sink(input valid, frame_index, overall_score, score_kw1, score_kw2,
               score_kw3, score_kw4, time_kw1, time_kw2, time_kw3, time_kw4,
               wake_hit, wake_latched, output ready);
endinterface

### sv/kws_posterior_confidence_core.sv
// ----------------------------------------------------------------------------
// kws_posterior_confidence_core
// Keyword-spotting confidence: smoothing, max-product DP and wake decision.
// ----------------------------------------------------------------------------
// Usage:
//   frames  : valid/ready channel, one word per frame (first_frame plus four
//             Q1.16 keyword posteriors). first_frame restarts the utterance.
//   results : valid/ready channel, one word per frame with frame index,
//             confidence, per-keyword scores and frames, wake hit and latch.
//   cfg_*   : write-only register port, written while the core is
//             idle; the core itself does not enforce this, so the user must.
// Throughput: one frame at a time. The shared 33-step divider and the window
//   walk over the DP RAM take most of the time of a frame.
// Reset clears the frame counter, the wake latch and the output valid flag;
//   configuration returns to its defaults. No clearing pass is needed.
// A stalled receiver holds the result in the output register; the next frame
//   is still accepted and held at its end until the register frees.
// ----------------------------------------------------------------------------
module kws_posterior_confidence_core (
  input  logic                                 clk,
  input  logic                                 rst,
  kwspc_frame_if.sink                          frames,
  kwspc_result_if.source                       results,
  input  logic                                 cfg_we,
  input  logic [kwspc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kwspc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  kwspc_pkg::cmd_t    cmd;
  kwspc_pkg::stat_t   stat;
  kwspc_pkg::kw_vec_t posts;

  assign posts = {frames.post_kw4, frames.post_kw3, frames.post_kw2, frames.post_kw1};

  kwspc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(frames.valid),
    .in_ready(frames.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  kwspc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .first_frame(frames.first_frame),
    .posts      (posts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .results    (results)
  );

endmodule

### sv/kwspc_ram.sv
// ----------------------------------------------------------------------------
// kwspc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kwspc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and a registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/kwspc_div.sv
// ----------------------------------------------------------------------------
// kwspc_div
// Restoring divider, one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module kwspc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [kwspc_pkg::DIV_NW-1:0]  dividend,
  input  logic [kwspc_pkg::DIV_DW-1:0]  divisor,
  output logic                          done,
  output logic [kwspc_pkg::DIV_NW-1:0]  quotient
);

  localparam int NW = kwspc_pkg::DIV_NW;
  localparam int DW = kwspc_pkg::DIV_DW;
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // One trial subtraction
  always_comb begin
    trial = {rem, quotient[NW-1]};
    diff  = trial - {1'b0, dsr};
    ge    = (trial >= {1'b0, dsr});
  end

  // Shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CW'(NW);
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quotient <= {quotient[NW-2:0], ge};
        cnt      <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### sv/kwspc_ctrl.sv
// ----------------------------------------------------------------------------
// kwspc_ctrl
// Sequencer: walks one frame through smoothing, DP, backtrack and root.
// ----------------------------------------------------------------------------
module kwspc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kwspc_pkg::stat_t  stat,
  output kwspc_pkg::cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_ZERO, S_SRD, S_SACC, S_SDGO, S_SDWT, S_SWR, S_DRD, S_DMUL,
    S_DUPD, S_BRD0, S_BLAT0, S_BRD, S_BLAT, S_BDGO, S_BDWT, S_RINIT, S_RMID,
    S_RPOW, S_RCMP, S_FIN
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  // Command for the current state
  always_comb begin
    case (state)
      S_IDLE:  cmd.op = in_valid ? kwspc_pkg::OP_ACCEPT : kwspc_pkg::OP_NONE;
      S_ZERO:  cmd.op = kwspc_pkg::OP_ZERO;
      S_SRD:   cmd.op = kwspc_pkg::OP_SRD;
      S_SACC:  cmd.op = kwspc_pkg::OP_SACC;
      S_SDGO:  cmd.op = kwspc_pkg::OP_SDGO;
      S_SDWT:  cmd.op = kwspc_pkg::OP_SDWT;
      S_SWR:   cmd.op = kwspc_pkg::OP_SWR;
      S_DRD:   cmd.op = kwspc_pkg::OP_DRD;
      S_DMUL:  cmd.op = kwspc_pkg::OP_DMUL;
      S_DUPD:  cmd.op = kwspc_pkg::OP_DUPD;
      S_BRD0:  cmd.op = kwspc_pkg::OP_BRD0;
      S_BLAT0: cmd.op = kwspc_pkg::OP_BLAT0;
      S_BRD:   cmd.op = kwspc_pkg::OP_BRD;
      S_BLAT:  cmd.op = kwspc_pkg::OP_BLAT;
      S_BDGO:  cmd.op = kwspc_pkg::OP_BDGO;
      S_BDWT:  cmd.op = kwspc_pkg::OP_BDWT;
      S_RINIT: cmd.op = kwspc_pkg::OP_RINIT;
      S_RMID:  cmd.op = kwspc_pkg::OP_RMID;
      S_RPOW:  cmd.op = kwspc_pkg::OP_RPOW;
      S_RCMP:  cmd.op = kwspc_pkg::OP_RCMP;
      S_FIN:   cmd.op = stat.out_free ? kwspc_pkg::OP_FIN : kwspc_pkg::OP_NONE;
      default: cmd.op = kwspc_pkg::OP_NONE;
    endcase
  end

  // Advance through the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (in_valid) state <= S_ZERO;
        S_ZERO:  state <= S_SRD;
        S_SRD:   state <= S_SACC;
        S_SACC:  state <= stat.sm_last ? S_SDGO : S_SRD;
        S_SDGO:  state <= S_SDWT;
        S_SDWT:  if (stat.div_done) state <= stat.lane_last ? S_SWR : S_SDGO;
        S_SWR:   state <= S_DRD;
        S_DRD:   state <= S_DMUL;
        S_DMUL:  state <= S_DUPD;
        S_DUPD:  state <= stat.dp_last ? S_BRD0 : S_DRD;
        S_BRD0:  state <= S_BLAT0;
        S_BLAT0: state <= stat.nk_one ? S_RINIT : S_BRD;
        S_BRD:   state <= S_BLAT;
        S_BLAT:  state <= S_BDGO;
        S_BDGO:  state <= S_BDWT;
        S_BDWT:  if (stat.div_done) state <= stat.bt_last ? S_RINIT : S_BRD;
        S_RINIT: state <= S_RMID;
        S_RMID:  state <= stat.root_open ? S_RPOW : S_FIN;
        S_RPOW:  if (stat.pow_done) state <= S_RCMP;
        S_RCMP:  state <= S_RMID;
        S_FIN:   if (stat.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/kwspc_dp.sv
// ----------------------------------------------------------------------------
// kwspc_dp
// Datapath: config registers, history RAMs, DP table, divider, root search.
// ----------------------------------------------------------------------------
module kwspc_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  kwspc_pkg::cmd_t                     cmd,
  output kwspc_pkg::stat_t                    stat,
  input  logic                                first_frame,
  input  kwspc_pkg::kw_vec_t                  posts,
  input  logic                                cfg_we,
  input  logic [kwspc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kwspc_pkg::CFG_DATA_W-1:0]    cfg_data,
  kwspc_result_if.source                      results
);

  localparam int NK = kwspc_pkg::MAX_KW;
  localparam int PW = kwspc_pkg::POST_W;
  localparam int RW = kwspc_pkg::ROW_W;
  localparam int FW = kwspc_pkg::FRAME_W;
  localparam int TW = kwspc_pkg::TIME_W;
  localparam int AW = kwspc_pkg::ACC_W;
  localparam int RAW_AW = kwspc_pkg::RAW_AW;
  localparam int WIN_AW = kwspc_pkg::WIN_AW;
  localparam int DP_AW  = kwspc_pkg::DP_AW;

  // Configuration registers
  logic [2:0]  cfg_nk;
  logic [4:0]  cfg_sw;
  logic [6:0]  cfg_mw;
  logic [6:0]  cfg_wgl;
  kwspc_pkg::post_t cfg_thr;

  // Frame state
  logic [FW-1:0]     fc;
  logic              flag;
  logic [FW-1:0]     j;
  logic [2:0]        nk;
  logic [4:0]        cnt;
  logic [RW-1:0]     len;
  logic [FW-1:0]     hm;
  logic [RAW_AW-1:0] rwp;
  logic [WIN_AW-1:0] swp;

  // Smoothing
  logic [RAW_AW-1:0] a;
  logic [AW-1:0]     acc [NK];
  logic [1:0]        lane;
  kwspc_pkg::kw_vec_t sm;

  // DP
  logic [RW-1:0]        k;
  kwspc_pkg::post_t     smp0;
  kwspc_pkg::post_t [NK-1:1] prod;
  kwspc_pkg::kw_vec_t   dps;
  kwspc_pkg::row_vec_t  dpr;
  kwspc_pkg::kw_vec_t   nsc;
  kwspc_pkg::row_vec_t  nrw;

  // Backtrack
  kwspc_pkg::dp_word_t  word;
  kwspc_pkg::row_t      pre;
  logic [1:0]           ib;
  kwspc_pkg::post_t     mul;
  kwspc_pkg::post_t     ps;
  kwspc_pkg::post_t     mtot;
  kwspc_pkg::kw_vec_t   sc;
  logic [TW-1:0]        tm [NK];

  // Root search
  kwspc_pkg::post_t lo;
  kwspc_pkg::post_t hi;
  kwspc_pkg::post_t mid;
  kwspc_pkg::post_t p;
  logic [2:0]       c;
  logic [PW:0]      mid_sum;

  // Output register
  logic                 out_valid;
  logic [FW-1:0]        o_frame;
  kwspc_pkg::post_t     o_overall;
  kwspc_pkg::kw_vec_t   o_sc;
  logic [FW-1:0]        o_tm [NK];
  logic                 o_hit;
  logic                 o_latched;

  // RAM ports
  kwspc_pkg::kw_vec_t   raw_rdata;
  kwspc_pkg::kw_vec_t   sm_rdata;
  kwspc_pkg::dp_word_t  dp_rdata;
  kwspc_pkg::dp_word_t  dp_wdata;
  logic [DP_AW-1:0]     dp_waddr;
  logic [DP_AW-1:0]     dp_raddr;
  logic [RW-1:0]        age;
  kwspc_pkg::kw_vec_t   sat_posts;

  // Divider
  logic                          div_start;
  logic [kwspc_pkg::DIV_NW-1:0]  div_n;
  logic [kwspc_pkg::DIV_DW-1:0]  div_d;
  logic                          div_done;
  logic [kwspc_pkg::DIV_NW-1:0]  div_q;

  // Accept-time derived values
  logic [FW-1:0] j_sel;
  logic [FW:0]   j1;
  logic [2:0]    nk_c;
  logic [4:0]    sw_c;
  logic [6:0]    mw_c;
  logic [4:0]    cnt_n;
  logic [RW-1:0] len_n;
  logic [FW:0]   hm_n;

  // Result assembly
  logic          gaps_ok;
  logic          hit;
  logic [TW:0]   gap;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_nk  <= 3'd4;
      cfg_sw  <= 5'd7;
      cfg_mw  <= 7'd30;
      cfg_wgl <= 7'd30;
      cfg_thr <= 17'd32768;
    end else if (cfg_we) begin
      case (kwspc_pkg::cfg_idx_t'(cfg_index))
        kwspc_pkg::CFG_NUM_KW:    cfg_nk  <= cfg_data[2:0];
        kwspc_pkg::CFG_SMOOTH:    cfg_sw  <= cfg_data[4:0];
        kwspc_pkg::CFG_MAX_WIN:   cfg_mw  <= cfg_data[6:0];
        kwspc_pkg::CFG_GAP_LIMIT: cfg_wgl <= cfg_data[6:0];
        kwspc_pkg::CFG_THRESHOLD: cfg_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp registers and size the windows for the new frame
  always_comb begin
    j_sel = first_frame ? '0 : fc;
    j1    = {1'b0, j_sel} + (FW+1)'(1);
    nk_c  = (cfg_nk == 3'd0) ? 3'd1 : ((cfg_nk > 3'(NK)) ? 3'(NK) : cfg_nk);
    sw_c  = (cfg_sw == 5'd0) ? 5'd1 :
            ((cfg_sw > 5'(kwspc_pkg::SMOOTH_DEPTH)) ? 5'(kwspc_pkg::SMOOTH_DEPTH) : cfg_sw);
    mw_c  = (cfg_mw == 7'd0) ? 7'd1 :
            ((cfg_mw > 7'(kwspc_pkg::WINDOW_DEPTH)) ? 7'(kwspc_pkg::WINDOW_DEPTH) : cfg_mw);
    cnt_n = (j1 < (FW+1)'(sw_c)) ? j1[4:0] : sw_c;
    len_n = (j1 < (FW+1)'(mw_c)) ? j1[RW-1:0] : mw_c;
    hm_n  = j1 - (FW+1)'(len_n);
    for (int g = 0; g < NK; g++) begin
      sat_posts[g] = kwspc_pkg::qsat(posts[g]);
    end
  end

  // New DP row from the previous one
  always_comb begin
    nsc = dps;
    nrw = dpr;
    if (!(smp0 < dps[0])) begin
      nsc[0] = smp0;
      nrw[0] = k;
    end
    for (int g = 1; g < NK; g++) begin
      if (k > RW'(g) && dps[g] < prod[g]) begin
        nsc[g] = prod[g];
        nrw[g] = k - RW'(1);
      end
    end
  end

  // Gap check and hit
  always_comb begin
    gaps_ok = 1'b1;
    gap     = '0;
    for (int g = 1; g < NK; g++) begin
      gap = {tm[g][TW-1], tm[g]} - {tm[g-1][TW-1], tm[g-1]};
      if (3'(g) < nk) begin
        if (gap[TW] || gap == '0 || gap >= (TW+1)'(cfg_wgl)) begin
          gaps_ok = 1'b0;
        end
      end
    end
    hit = (lo >= cfg_thr) && gaps_ok;
  end

  assign mid_sum = {1'b0, lo} + {1'b0, hi} + (PW+1)'(1);

  // RAM address and write data selection
  assign age      = len - k;
  assign dp_waddr = (cmd.op == kwspc_pkg::OP_DUPD) ? k : '0;
  assign dp_wdata = (cmd.op == kwspc_pkg::OP_DUPD) ? {nrw, nsc} : '0;
  assign dp_raddr = (cmd.op == kwspc_pkg::OP_BRD0) ? len : word.row[ib];

  kwspc_ram #(
    .WIDTH($bits(kwspc_pkg::kw_vec_t)),
    .DEPTH(kwspc_pkg::SMOOTH_DEPTH)
  ) u_raw_ram (
    .clk  (clk),
    .we   (cmd.op == kwspc_pkg::OP_ACCEPT),
    .waddr(rwp + RAW_AW'(1)),
    .wdata(sat_posts),
    .raddr(rwp - a),
    .rdata(raw_rdata)
  );

  kwspc_ram #(
    .WIDTH($bits(kwspc_pkg::kw_vec_t)),
    .DEPTH(kwspc_pkg::WINDOW_DEPTH)
  ) u_sm_ram (
    .clk  (clk),
    .we   (cmd.op == kwspc_pkg::OP_SWR),
    .waddr(swp + WIN_AW'(1)),
    .wdata(sm),
    .raddr(swp - age[WIN_AW-1:0]),
    .rdata(sm_rdata)
  );

  kwspc_ram #(
    .WIDTH($bits(kwspc_pkg::dp_word_t)),
    .DEPTH(kwspc_pkg::DP_DEPTH)
  ) u_dp_ram (
    .clk  (clk),
    .we   (cmd.op == kwspc_pkg::OP_ZERO || cmd.op == kwspc_pkg::OP_DUPD),
    .waddr(dp_waddr),
    .wdata(dp_wdata),
    .raddr(dp_raddr),
    .rdata(dp_rdata)
  );

  // Shared divider: smoothing averages and backtrack ratios
  assign div_start = (cmd.op == kwspc_pkg::OP_SDGO) || (cmd.op == kwspc_pkg::OP_BDGO);
  assign div_n = (cmd.op == kwspc_pkg::OP_SDGO) ? kwspc_pkg::DIV_NW'(acc[lane])
                                                : {mul, 16'd0};
  assign div_d = (cmd.op == kwspc_pkg::OP_SDGO) ? kwspc_pkg::DIV_DW'(cnt) : ps;

  kwspc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_n),
    .divisor (div_d),
    .done    (div_done),
    .quotient(div_q)
  );

  // Status back to the sequencer
  always_comb begin
    stat.sm_last   = ({1'b0, a} + 5'd1) == cnt;
    stat.lane_last = (lane == 2'd3);
    stat.div_done  = div_done;
    stat.dp_last   = (k == len);
    stat.nk_one    = (nk == 3'd1);
    stat.bt_last   = (ib == 2'd1);
    stat.root_open = (lo < hi);
    stat.pow_done  = (c >= nk);
    stat.out_free  = !out_valid || results.ready;
  end

  // Control state: counter, wake latch, pointers, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      fc        <= '0;
      flag      <= 1'b0;
      rwp       <= '0;
      swp       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == kwspc_pkg::OP_FIN) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        kwspc_pkg::OP_ACCEPT: begin
          rwp <= rwp + RAW_AW'(1);
          if (first_frame) begin
            flag <= 1'b0;
          end
        end
        kwspc_pkg::OP_SWR: swp <= swp + WIN_AW'(1);
        kwspc_pkg::OP_FIN: begin
          flag      <= flag | hit;
          fc        <= (j != {FW{1'b1}}) ? j + FW'(1) : j;
        end
        default: ;
      endcase
    end
  end

  // Frame datapath
  always_ff @(posedge clk) begin
    case (cmd.op)
      kwspc_pkg::OP_ACCEPT: begin
        j   <= j_sel;
        nk  <= nk_c;
        cnt <= cnt_n;
        len <= len_n;
        hm  <= hm_n[FW-1:0];
      end
      // Clear DP row zero, accumulators and lane
      kwspc_pkg::OP_ZERO: begin
        dps  <= '0;
        dpr  <= '0;
        a    <= '0;
        lane <= '0;
        for (int g = 0; g < NK; g++) acc[g] <= '0;
      end
      // Sum the newest cnt raw frames
      kwspc_pkg::OP_SACC: begin
        for (int g = 0; g < NK; g++) acc[g] <= acc[g] + AW'(raw_rdata[g]);
        a <= a + RAW_AW'(1);
      end
      kwspc_pkg::OP_SDWT: begin
        if (div_done) begin
          sm[lane] <= div_q[PW-1:0];
          lane     <= lane + 2'd1;
        end
      end
      kwspc_pkg::OP_SWR: k <= RW'(1);
      // Multiply each keyword after the first against the previous row
      kwspc_pkg::OP_DMUL: begin
        smp0 <= sm_rdata[0];
        for (int g = 1; g < NK; g++) prod[g] <= kwspc_pkg::qmul(dps[g-1], sm_rdata[g]);
      end
      kwspc_pkg::OP_DUPD: begin
        dps <= nsc;
        dpr <= nrw;
        k   <= k + RW'(1);
      end
      // Start backtrack from the last row
      kwspc_pkg::OP_BLAT0: begin
        word <= dp_rdata;
        mul  <= dp_rdata.score[nk[1:0] - 2'd1];
        mtot <= dp_rdata.score[nk[1:0] - 2'd1];
        ib   <= nk[1:0] - 2'd1;
      end
      kwspc_pkg::OP_BRD: pre <= word.row[ib];
      kwspc_pkg::OP_BLAT: begin
        word   <= dp_rdata;
        ps     <= dp_rdata.score[ib - 2'd1];
        tm[ib] <= TW'(pre) + TW'(hm);
      end
      kwspc_pkg::OP_BDGO: mul <= ps;
      kwspc_pkg::OP_BDWT: begin
        if (div_done) begin
          if (ps == '0) begin
            sc[ib] <= '0;
          end else if (div_q > kwspc_pkg::DIV_NW'(kwspc_pkg::Q_ONE)) begin
            sc[ib] <= kwspc_pkg::Q_ONE;
          end else begin
            sc[ib] <= div_q[PW-1:0];
          end
          ib <= ib - 2'd1;
        end
      end
      // First keyword, then bound the root search
      kwspc_pkg::OP_RINIT: begin
        sc[0] <= word.score[0];
        tm[0] <= TW'(word.row[0]) + TW'(hm) - TW'(1);
        lo    <= '0;
        hi    <= kwspc_pkg::Q_ONE;
      end
      kwspc_pkg::OP_RMID: begin
        mid <= mid_sum[PW:1];
        p   <= mid_sum[PW:1];
        c   <= 3'd1;
      end
      kwspc_pkg::OP_RPOW: begin
        if (c < nk) begin
          p <= kwspc_pkg::qmul(p, mid);
          c <= c + 3'd1;
        end
      end
      kwspc_pkg::OP_RCMP: begin
        if (p <= mtot) begin
          lo <= mid;
        end else begin
          hi <= mid - PW'(1);
        end
      end
      // Load the output word
      kwspc_pkg::OP_FIN: begin
        o_frame   <= j;
        o_overall <= lo;
        o_hit     <= hit;
        o_latched <= flag | hit;
        for (int g = 0; g < NK; g++) begin
          if (3'(g) < nk) begin
            o_sc[g] <= sc[g];
            o_tm[g] <= tm[g][TW-1] ? '0 : tm[g][FW-1:0];
          end else begin
            o_sc[g] <= '0;
            o_tm[g] <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign results.valid         = out_valid;
  assign results.frame_index   = o_frame;
  assign results.overall_score = o_overall;
  assign results.score_kw1     = o_sc[0];
  assign results.score_kw2     = o_sc[1];
  assign results.score_kw3     = o_sc[2];
  assign results.score_kw4     = o_sc[3];
  assign results.time_kw1      = o_tm[0];
  assign results.time_kw2      = o_tm[1];
  assign results.time_kw3      = o_tm[2];
  assign results.time_kw4      = o_tm[3];
  assign results.wake_hit      = o_hit;
  assign results.wake_latched  = o_latched;

endmodule

### test/tb_kws_posterior_confidence_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kws_posterior_confidence_core
// Self-checking bench for the keyword posterior confidence core. Frames go in
// over the frame channel, and every result word is compared field by field
// with a bit-accurate prediction of smoothing, the max-product DP, backtrack,
// root and wake decision. Directed frames and configuration extremes come
// first, then random phrase-shaped utterances, most under random flow control.
// ----------------------------------------------------------------------------
module tb_kws_posterior_confidence_core;

  localparam logic [kwspc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;
  localparam int SETTLE_CYCLES = 700;

  typedef struct {
    logic [15:0]      index;
    kwspc_pkg::post_t overall;
    kwspc_pkg::post_t score [kwspc_pkg::MAX_KW];
    logic [15:0]      stamp [kwspc_pkg::MAX_KW];
    logic             hit;
    logic             latched;
  } conf_word_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [kwspc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [kwspc_pkg::CFG_DATA_W-1:0] cfg_data;

  kwspc_frame_if  frames_if ();
  kwspc_result_if results_if ();

  kws_posterior_confidence_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .frames    (frames_if.sink),
    .results   (results_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state
  logic [2:0]  reg_nk;
  logic [4:0]  reg_sw;
  logic [6:0]  reg_mw;
  logic [6:0]  reg_gap;
  logic [16:0] reg_thr;
  longint raw_hist [kwspc_pkg::SMOOTH_DEPTH][kwspc_pkg::MAX_KW];
  longint sm_hist [kwspc_pkg::WINDOW_DEPTH][kwspc_pkg::MAX_KW];
  int     frame_cnt;
  bit     wake_seen;

  conf_word_t expected_q [$];
  int   error_count;
  bit   flow_gaps;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint qm(longint a, longint b);
    return (a * b) >> 16;
  endfunction

  function automatic longint qroot_n(longint v, int n);
    longint lo, hi, mid, p;
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      p = mid;
      for (int c = 1; c < n; c++) p = qm(p, mid);
      if (p <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Work out the confidence word for one accepted frame
  function automatic conf_word_t confidence_of(logic ff, kwspc_pkg::post_t p [kwspc_pkg::MAX_KW]);
    conf_word_t r;
    int j, nk, sw, mw, cnt, len, hm, cur, pre, gap;
    longint dps [kwspc_pkg::WINDOW_DEPTH+1][kwspc_pkg::MAX_KW];
    int     dpr [kwspc_pkg::WINDOW_DEPTH+1][kwspc_pkg::MAX_KW];
    longint sum, s, pr, mul, ps, overall;
    longint sc [kwspc_pkg::MAX_KW];
    int     tm [kwspc_pkg::MAX_KW];
    bit     gaps_ok;
    if (ff) begin
      foreach (raw_hist[a, b]) raw_hist[a][b] = 0;
      foreach (sm_hist[a, b]) sm_hist[a][b] = 0;
      frame_cnt = 0;
      wake_seen = 0;
    end
    j  = frame_cnt;
    nk = clampi(reg_nk, 1, kwspc_pkg::MAX_KW);
    sw = clampi(reg_sw, 1, kwspc_pkg::SMOOTH_DEPTH);
    mw = clampi(reg_mw, 1, kwspc_pkg::WINDOW_DEPTH);
    for (int a = kwspc_pkg::SMOOTH_DEPTH - 1; a >= 1; a--) raw_hist[a] = raw_hist[a-1];
    for (int a = kwspc_pkg::WINDOW_DEPTH - 1; a >= 1; a--) sm_hist[a] = sm_hist[a-1];
    cnt = (j + 1 < sw) ? j + 1 : sw;
    for (int i = 0; i < kwspc_pkg::MAX_KW; i++) begin
      raw_hist[0][i] = (p[i] > kwspc_pkg::Q_ONE) ? 65536 : p[i];
      sum = 0;
      for (int a = 0; a < cnt; a++) sum += raw_hist[a][i];
      sm_hist[0][i] = sum / cnt;
    end
    len = (j + 1 < mw) ? j + 1 : mw;
    hm  = j + 1 - len;
    foreach (dps[a, b]) begin
      dps[a][b] = 0;
      dpr[a][b] = 0;
    end
    for (int k = 1; k <= len; k++) begin
      s = sm_hist[len-k][0];
      if (s < dps[k-1][0]) begin
        dps[k][0] = dps[k-1][0];
        dpr[k][0] = dpr[k-1][0];
      end else begin
        dps[k][0] = s;
        dpr[k][0] = k;
      end
    end
    for (int i = 1; i < nk; i++) begin
      for (int k = i + 1; k <= len; k++) begin
        pr = qm(dps[k-1][i-1], sm_hist[len-k][i]);
        dps[k][i] = dps[k-1][i];
        dpr[k][i] = dpr[k-1][i];
        if (dps[k][i] < pr) begin
          dps[k][i] = pr;
          dpr[k][i] = k - 1;
        end
      end
    end
    // Backtrack along the best path
    mul = dps[len][nk-1];
    overall = qroot_n(mul, nk);
    cur = len;
    for (int i = nk - 1; i >= 1; i--) begin
      pre = dpr[cur][i];
      if (pre > kwspc_pkg::WINDOW_DEPTH) pre = kwspc_pkg::WINDOW_DEPTH;
      ps = dps[pre][i-1];
      if (ps == 0) sc[i] = 0;
      else sc[i] = ((mul << 16) / ps > 65536) ? 65536 : (mul << 16) / ps;
      tm[i] = pre + hm;
      mul = ps;
      cur = pre;
    end
    sc[0] = dps[cur][0];
    tm[0] = dpr[cur][0] + hm - 1;
    gaps_ok = 1;
    for (int i = 1; i < nk; i++) begin
      gap = tm[i] - tm[i-1];
      if (gap >= int'(reg_gap) || gap <= 0) gaps_ok = 0;
    end
    r.hit = (overall >= reg_thr) && gaps_ok;
    if (r.hit) wake_seen = 1;
    r.index   = j[15:0];
    r.overall = kwspc_pkg::post_t'(overall);
    for (int i = 0; i < kwspc_pkg::MAX_KW; i++) begin
      r.score[i] = (i < nk) ? kwspc_pkg::post_t'(sc[i]) : '0;
      r.stamp[i] = (i < nk && tm[i] > 0) ? 16'(tm[i]) : 16'd0;
    end
    r.latched = wake_seen;
    frame_cnt = (j < 65535) ? j + 1 : 65535;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t: %s mismatch, got %0d, want %0d", $realtime, field, got, want);
    error_count++;
  endtask

  // Check each accepted result word against the oldest prediction
  always @(posedge clk) begin
    conf_word_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result word with nothing pending", $realtime);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (results_if.frame_index !== want.index)
          report_mismatch("frame_index", results_if.frame_index, want.index);
        if (results_if.overall_score !== want.overall)
          report_mismatch("overall_score", results_if.overall_score, want.overall);
        if (results_if.score_kw1 !== want.score[0])
          report_mismatch("score_kw1", results_if.score_kw1, want.score[0]);
        if (results_if.score_kw2 !== want.score[1])
          report_mismatch("score_kw2", results_if.score_kw2, want.score[1]);
        if (results_if.score_kw3 !== want.score[2])
          report_mismatch("score_kw3", results_if.score_kw3, want.score[2]);
        if (results_if.score_kw4 !== want.score[3])
          report_mismatch("score_kw4", results_if.score_kw4, want.score[3]);
        if (results_if.time_kw1 !== want.stamp[0])
          report_mismatch("time_kw1", results_if.time_kw1, want.stamp[0]);
        if (results_if.time_kw2 !== want.stamp[1])
          report_mismatch("time_kw2", results_if.time_kw2, want.stamp[1]);
        if (results_if.time_kw3 !== want.stamp[2])
          report_mismatch("time_kw3", results_if.time_kw3, want.stamp[2]);
        if (results_if.time_kw4 !== want.stamp[3])
          report_mismatch("time_kw4", results_if.time_kw4, want.stamp[3]);
        if (results_if.wake_hit !== want.hit)
          report_mismatch("wake_hit", results_if.wake_hit, want.hit);
        if (results_if.wake_latched !== want.latched)
          report_mismatch("wake_latched", results_if.wake_latched, want.latched);
      end
    end
  end

  // Receiver stalls in random bursts
  initial begin
    results_if.ready = 1'b0;
    forever begin
      if (flow_gaps && $urandom_range(0, 2) == 0) results_if.ready <= 1'b0;
      else results_if.ready <= 1'b1;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  end

  task automatic send_frame(logic ff, kwspc_pkg::post_t p0, kwspc_pkg::post_t p1,
                            kwspc_pkg::post_t p2, kwspc_pkg::post_t p3);
    kwspc_pkg::post_t p [kwspc_pkg::MAX_KW];
    if (flow_gaps && $urandom_range(0, 3) == 0) begin
      frames_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    frames_if.valid       <= 1'b1;
    frames_if.first_frame <= ff;
    frames_if.post_kw1    <= p0;
    frames_if.post_kw2    <= p1;
    frames_if.post_kw3    <= p2;
    frames_if.post_kw4    <= p3;
    @(posedge clk);
    while (!frames_if.ready) @(posedge clk);
    p = '{p0, p1, p2, p3};
    expected_q.push_back(confidence_of(ff, p));
  endtask

  // Drop valid and hold until every pending word has come back
  task automatic drain;
    frames_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // One register write, then the port idles and the predictor's copy is updated
  task automatic write_reg(logic [kwspc_pkg::CFG_IDX_W-1:0] idx,
                           logic [kwspc_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      kwspc_pkg::CFG_NUM_KW:    reg_nk  = value[2:0];
      kwspc_pkg::CFG_SMOOTH:    reg_sw  = value[4:0];
      kwspc_pkg::CFG_MAX_WIN:   reg_mw  = value[6:0];
      kwspc_pkg::CFG_GAP_LIMIT: reg_gap = value[6:0];
      kwspc_pkg::CFG_THRESHOLD: reg_thr = value[16:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int nk, int sw, int mw, int gap, int thr);
    write_reg(kwspc_pkg::CFG_NUM_KW, kwspc_pkg::CFG_DATA_W'(nk));
    write_reg(kwspc_pkg::CFG_SMOOTH, kwspc_pkg::CFG_DATA_W'(sw));
    write_reg(kwspc_pkg::CFG_MAX_WIN, kwspc_pkg::CFG_DATA_W'(mw));
    write_reg(kwspc_pkg::CFG_GAP_LIMIT, kwspc_pkg::CFG_DATA_W'(gap));
    write_reg(kwspc_pkg::CFG_THRESHOLD, kwspc_pkg::CFG_DATA_W'(thr));
  endtask

  function automatic kwspc_pkg::post_t rand_post();
    case ($urandom_range(0, 5))
      0: return kwspc_pkg::post_t'($urandom_range(0, 131071));
      1: return kwspc_pkg::Q_ONE;
      2: return kwspc_pkg::post_t'($urandom_range(50000, 65536));
      default: return kwspc_pkg::post_t'($urandom_range(0, 20000));
    endcase
  endfunction

  // Reset defaults, first frame missing, then extreme posteriors
  task automatic test_defaults;
    send_frame(1'b0, 17'd0, 17'd0, 17'd0, 17'd0);
    send_frame(1'b0, kwspc_pkg::Q_ONE, 17'd0, 17'd0, 17'd0);
    send_frame(1'b0, 17'h1FFFF, 17'd65537, 17'h15555, 17'h0AAAA);
    send_frame(1'b0, 17'd0, kwspc_pkg::Q_ONE, 17'd0, 17'd0);
    send_frame(1'b0, 17'd0, 17'd0, kwspc_pkg::Q_ONE, 17'd0);
    send_frame(1'b0, 17'd0, 17'd0, 17'd0, kwspc_pkg::Q_ONE);
    send_frame(1'b1, kwspc_pkg::Q_ONE, kwspc_pkg::Q_ONE, kwspc_pkg::Q_ONE, kwspc_pkg::Q_ONE);
    drain();
  endtask

  // Registers at and beyond their limits, a short ideal phrase for each
  task automatic test_config_extremes;
    int cfgs [6][5] = '{
      '{0, 0, 0, 1, 0},
      '{7, 31, 127, 127, 131071},
      '{1, 1, 1, 64, 65536},
      '{4, 16, 64, 64, 0},
      '{4, 1, 2, 2, 1000},
      '{3, 2, 3, 5, 32768}
    };
    for (int c = 0; c < 6; c++) begin
      set_config(cfgs[c][0], cfgs[c][1], cfgs[c][2], cfgs[c][3], cfgs[c][4]);
      write_reg(CFG_UNUSED, 17'h1FFFF);
      send_frame(1'b1, kwspc_pkg::Q_ONE, 17'd0, 17'd0, 17'd0);
      send_frame(1'b0, 17'd0, kwspc_pkg::Q_ONE, 17'd0, 17'd0);
      send_frame(1'b0, 17'd0, 17'd0, kwspc_pkg::Q_ONE, 17'd0);
      send_frame(1'b0, 17'd0, 17'd0, 17'd0, kwspc_pkg::Q_ONE);
      drain();
    end
  endtask

  // Phrase-shaped utterances under random settings
  task automatic test_random_utterances(int phases);
    int n, span, peak, kw;
    kwspc_pkg::post_t p [kwspc_pkg::MAX_KW];
    for (int ph = 0; ph < phases; ph++) begin
      if ($urandom_range(0, 7) == 0)
        set_config($urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 127),
                   $urandom_range(0, 127), $urandom_range(0, 131071));
      else
        set_config($urandom_range(1, 4), $urandom_range(1, 8), $urandom_range(4, 40),
                   $urandom_range(3, 40), $urandom_range(0, 3) == 0 ?
                   $urandom_range(0, 131071) : $urandom_range(20000, 60000));
      n = $urandom_range(20, 70);
      span = $urandom_range(2, 8);
      for (int f = 0; f < n; f++) begin
        kw = f / span;
        for (int i = 0; i < kwspc_pkg::MAX_KW; i++) begin
          if ($urandom_range(0, 9) == 0) p[i] = rand_post();
          else if (i == kw % 6) p[i] = kwspc_pkg::post_t'($urandom_range(40000, 70000));
          else p[i] = kwspc_pkg::post_t'($urandom_range(0, 8000));
        end
        send_frame(f == 0 ? 1'b1 : ($urandom_range(0, 60) == 0),
                   p[0], p[1], p[2], p[3]);
      end
      drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    frames_if.valid = 1'b0;
    frames_if.first_frame = 1'b0;
    frames_if.post_kw1 = '0;
    frames_if.post_kw2 = '0;
    frames_if.post_kw3 = '0;
    frames_if.post_kw4 = '0;
    error_count = 0;
    flow_gaps = 1'b1;
    reg_nk = 3'd4;
    reg_sw = 5'd7;
    reg_mw = 7'd30;
    reg_gap = 7'd30;
    reg_thr = 17'd32768;
    foreach (raw_hist[a, b]) raw_hist[a][b] = 0;
    foreach (sm_hist[a, b]) sm_hist[a][b] = 0;
    frame_cnt = 0;
    wake_seen = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_config_extremes();
    test_random_utterances(21);
    flow_gaps = 1'b0;
    test_random_utterances(4);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("tb_kws_posterior_confidence_core: done, clean");
    end else begin
      $display("tb_kws_posterior_confidence_core: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #60ms;
    $display("tb_kws_posterior_confidence_core: done, errors");
    $finish;
  end

endmodule

### sim.f
sv/kwspc_pkg.sv
sv/kwspc_if.sv
sv/kwspc_ram.sv
sv/kwspc_div.sv
sv/kwspc_ctrl.sv
sv/kwspc_dp.sv
sv/kws_posterior_confidence_core.sv
test/tb_kws_posterior_confidence_core.sv
